[hdl/ultrasonic_range_median_filter_macros.svh]
// assertion macros for the ultrasonic range median filter checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef ULTRASONIC_RANGE_MEDIAN_FILTER_MACROS_SVH
`define ULTRASONIC_RANGE_MEDIAN_FILTER_MACROS_SVH

`define URMF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("urmf same-cycle check failed");

`define URMF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("urmf next-cycle check failed");

`endif

[hdl/urmf_pkg.sv]
// types and constants for the ultrasonic range median filter
// no dependencies
package urmf_pkg;

    localparam int DIST_W    = 16;
    localparam int TICK_W    = 32;
    localparam int US_W      = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    localparam int CH_W      = 1;
    localparam int CH_LIMIT  = 2 ** CH_W;

    localparam int RING_DEPTH = 3;
    localparam int RING_IDX_W = 2;

    localparam int MIN_DIST_RST  = 20;
    localparam int MAX_DIST_RST  = 4000;
    localparam int STALE_RST     = 10000000;

    // distance = (us*1715 + 5000) / 10000, reduced by 5, then a reciprocal multiply
    localparam int DIST_GCD   = 5;
    localparam int DIST_NUM   = 1715 / DIST_GCD;
    localparam int DIST_OFS   = 5000 / DIST_GCD;
    localparam int DIST_DEN   = 10000 / DIST_GCD;
    localparam int DIST_SHIFT = 46;
    localparam int PROD_W     = DIST_SHIFT + DIST_W;

    localparam longint unsigned DIST_RECIP =
        ((64'd1 << DIST_SHIFT) + 64'(DIST_DEN) - 64'd1) / 64'(DIST_DEN);
    localparam logic [PROD_W-1:0] DIST_GAIN = PROD_W'(64'(DIST_NUM) * DIST_RECIP);
    localparam logic [PROD_W-1:0] DIST_BIAS = PROD_W'(64'(DIST_OFS) * DIST_RECIP);

    typedef logic [DIST_W-1:0]     t_dist;
    typedef logic [TICK_W-1:0]     t_tick;
    typedef logic [RING_IDX_W-1:0] t_ring_idx;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DISTANCE = 8'd0,
        CFG_MAX_DISTANCE = 8'd1,
        CFG_STALE_TICKS  = 8'd2
    } t_cfg_reg;

endpackage

[hdl/ultrasonic_range_median_filter.sv]
// ultrasonic echo range filter, top level
// depends on urmf_pkg
//
// One measurement is accepted per cycle while o_in_stall is low; the
// transaction is captured in an input register, then converted,
// range-checked, written into its channel's three-sample ring and smoothed
// (pass-through, average or median) in one step that loads the result
// register and the channel state together. The distance conversion is a
// single constant multiply. Results of the same channel follow each other
// back to back with no hazard. Channel state is ready straight out of reset.
module ultrasonic_range_median_filter
    import urmf_pkg::*;
#(
    parameter int CHANNELS = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CH_W-1:0]      i_channel,
    input  logic                 i_echo_seen,
    input  logic [US_W-1:0]      i_pulse_us,
    input  logic [TICK_W-1:0]    i_now_tick,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CH_W-1:0]      o_out_channel,
    output logic [DIST_W-1:0]    o_filtered_distance,
    output logic                 o_sample_accepted,
    output logic                 o_fresh
);

    localparam int ROWS = (CHANNELS < CH_LIMIT) ? CHANNELS : CH_LIMIT;

    t_dist r_min_dist;
    t_dist r_max_dist;
    t_tick r_stale;

    logic              r_in_valid;
    logic [CH_W-1:0]   r_in_channel;
    logic              r_in_echo;
    logic [US_W-1:0]   r_in_us;
    t_tick             r_in_now;

    logic              r_out_valid;
    logic [CH_W-1:0]   r_out_channel;
    t_dist             r_out_dist;
    logic              r_out_accepted;
    logic              r_out_fresh;

    t_dist     r_ring [ROWS][RING_DEPTH];
    t_ring_idx r_pos  [ROWS];
    t_ring_idx r_fill [ROWS];
    t_dist     r_held [ROWS];
    t_tick     r_last [ROWS];
    logic      r_seen [ROWS];

    logic             out_free;
    logic             advance;
    logic             in_take;
    logic [ROWS-1:0]  row_hit;

    t_dist            cur_ring [RING_DEPTH];
    t_ring_idx        cur_pos;
    t_ring_idx        cur_fill;
    t_dist            cur_held;
    t_tick            cur_last;
    logic             cur_seen;

    logic [PROD_W-1:0] dist_prod;
    t_dist             conv_dist;
    logic              ch_ok;
    logic              accept;
    t_ring_idx         pos;
    t_ring_idx         n_pos;
    t_ring_idx         n_fill;
    t_dist             n_ring [RING_DEPTH];
    logic [DIST_W:0]   pair_sum;
    t_dist             lo_ab;
    t_dist             hi_ab;
    t_dist             mid_c;
    t_dist             median;
    t_dist             n_held;
    t_tick             age;

    t_dist             n_out_dist;
    logic              n_out_fresh;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= t_dist'(MIN_DIST_RST);
            r_max_dist <= t_dist'(MAX_DIST_RST);
            r_stale    <= t_tick'(STALE_RST);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_MIN_DISTANCE: r_min_dist <= i_cfg_data[DIST_W-1:0];
                CFG_MAX_DISTANCE: r_max_dist <= i_cfg_data[DIST_W-1:0];
                CFG_STALE_TICKS:  r_stale    <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_channel <= i_channel;
            r_in_echo    <= i_echo_seen;
            r_in_us      <= i_pulse_us;
            r_in_now     <= i_now_tick;
        end
    end

    // channel row select
    always_comb begin
        for (int k = 0; k < RING_DEPTH; k++) begin
            cur_ring[k] = '0;
        end
        cur_pos  = '0;
        cur_fill = '0;
        cur_held = '0;
        cur_last = '0;
        cur_seen = 1'b0;
        for (int g = 0; g < ROWS; g++) begin
            if (row_hit[g]) begin
                for (int k = 0; k < RING_DEPTH; k++) begin
                    cur_ring[k] = r_ring[g][k];
                end
                cur_pos  = r_pos[g];
                cur_fill = r_fill[g];
                cur_held = r_held[g];
                cur_last = r_last[g];
                cur_seen = r_seen[g];
            end
        end
    end

    // conversion and range check
    assign dist_prod = PROD_W'(r_in_us) * DIST_GAIN + DIST_BIAS;
    assign conv_dist = dist_prod[DIST_SHIFT +: DIST_W];
    assign ch_ok     = 32'(r_in_channel) < 32'(CHANNELS);
    assign accept    = ch_ok && r_in_echo && (conv_dist >= r_min_dist)
                       && (conv_dist <= r_max_dist);

    // ring update and smoothing
    assign pos    = (cur_pos >= t_ring_idx'(RING_DEPTH)) ? '0 : cur_pos;
    assign n_pos  = (pos == t_ring_idx'(RING_DEPTH - 1)) ? '0 : pos + t_ring_idx'(1);
    assign n_fill = (cur_fill < t_ring_idx'(RING_DEPTH)) ? cur_fill + t_ring_idx'(1)
                                                          : cur_fill;

    always_comb begin
        for (int k = 0; k < RING_DEPTH; k++) begin
            n_ring[k] = (pos == t_ring_idx'(k)) ? conv_dist : cur_ring[k];
        end
    end

    assign pair_sum = {1'b0, n_ring[0]} + {1'b0, n_ring[1]};
    assign lo_ab    = (n_ring[0] < n_ring[1]) ? n_ring[0] : n_ring[1];
    assign hi_ab    = (n_ring[0] < n_ring[1]) ? n_ring[1] : n_ring[0];
    assign mid_c    = (hi_ab < n_ring[2]) ? hi_ab : n_ring[2];
    assign median   = (lo_ab > mid_c) ? lo_ab : mid_c;

    always_comb begin
        unique case (n_fill)
            2'd0: n_held = '0;
            2'd1: n_held = n_ring[0];
            2'd2: n_held = pair_sum[DIST_W:1];
            2'd3: n_held = median;
        endcase
    end

    assign age = r_in_now - cur_last;

    always_comb begin
        n_out_dist  = '0;
        n_out_fresh = 1'b0;
        if (ch_ok) begin
            n_out_dist  = accept ? n_held : cur_held;
            n_out_fresh = accept || (cur_seen && (age <= r_stale));
        end
    end

    // per-channel state
    for (genvar g = 0; g < ROWS; g++) begin : g_row
        assign row_hit[g] = (32'(r_in_channel) == 32'(g));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pos[g]  <= '0;
                r_fill[g] <= '0;
                r_held[g] <= '0;
                r_last[g] <= '0;
                r_seen[g] <= 1'b0;
            end else if (advance && accept && row_hit[g]) begin
                r_pos[g]  <= n_pos;
                r_fill[g] <= n_fill;
                r_held[g] <= n_held;
                r_last[g] <= r_in_now;
                r_seen[g] <= 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (advance && accept && row_hit[g]) begin
                for (int k = 0; k < RING_DEPTH; k++) begin
                    r_ring[g][k] <= n_ring[k];
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_channel  <= r_in_channel;
            r_out_dist     <= n_out_dist;
            r_out_accepted <= accept;
            r_out_fresh    <= n_out_fresh;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_channel       = r_out_channel;
    assign o_filtered_distance = r_out_dist;
    assign o_sample_accepted   = r_out_accepted;
    assign o_fresh             = r_out_fresh;

endmodule

[hdl/urmf_checker.sv]
// port-level checks for the ultrasonic range median filter, bound to the top level
// depends on urmf_pkg and ultrasonic_range_median_filter_macros.svh
`include "ultrasonic_range_median_filter_macros.svh"

module urmf_checker
    import urmf_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [CH_W-1:0]   o_out_channel,
    input logic [DIST_W-1:0] o_filtered_distance,
    input logic              o_sample_accepted,
    input logic              o_fresh
);

    // a stalled result transaction holds
    `URMF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_channel) && $stable(o_filtered_distance) &&
        $stable(o_sample_accepted) && $stable(o_fresh))

    // an accepted sample is fresh by definition
    `URMF_ASSERT_NOW(a_acc_fresh, o_out_valid && o_sample_accepted, o_fresh)

    // with the result register empty the input side never stalls
    `URMF_ASSERT_NOW(a_no_stall_empty, !o_out_valid, !o_in_stall)

endmodule

bind ultrasonic_range_median_filter urmf_checker u_urmf_checker (.*);

[bench/ultrasonic_range_median_filter_tb.sv]
// self-checking bench for ultrasonic_range_median_filter: directed and random echo
// measurements with register changes, results checked against an in-bench predictor
// depends on urmf_pkg and the filter top level
module ultrasonic_range_median_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import urmf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 150;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFF;

    typedef struct packed {
        logic              ch;
        logic              echo;
        logic [US_W-1:0]   us;
        t_tick             tick;
    } t_echo_meas;

    typedef struct packed {
        logic  ch;
        t_dist filt;
        logic  acc;
        logic  fresh;
    } t_range_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [CH_W-1:0]      i_channel = '0;
    logic                 i_echo_seen = 1'b0;
    logic [US_W-1:0]      i_pulse_us = '0;
    t_tick                i_now_tick = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [CH_W-1:0]      o_out_channel;
    t_dist                o_filtered_distance;
    logic                 o_sample_accepted;
    logic                 o_fresh;

    ultrasonic_range_median_filter #(
        .CHANNELS(2)
    ) DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_channel           (i_channel),
        .i_echo_seen         (i_echo_seen),
        .i_pulse_us          (i_pulse_us),
        .i_now_tick          (i_now_tick),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_channel       (o_out_channel),
        .o_filtered_distance (o_filtered_distance),
        .o_sample_accepted   (o_sample_accepted),
        .o_fresh             (o_fresh)
    );

    always #10 i_clk = ~i_clk;

    // predictor copy of the registers and channel state
    t_dist     lim_min = t_dist'(MIN_DIST_RST);
    t_dist     lim_max = t_dist'(MAX_DIST_RST);
    t_tick     lim_stale = t_tick'(STALE_RST);
    t_dist     ring_mem [2][3];
    t_ring_idx wr_pos [2] = '{default: '0};
    t_ring_idx fill_cnt [2] = '{default: '0};
    t_dist     held_dist [2] = '{default: '0};
    t_tick     last_tick [2] = '{default: '0};
    logic      seen_ok [2] = '{default: 1'b0};

    t_echo_meas    pending_meas [$];
    t_range_result due_results [$];
    int unsigned   err_count = 0;
    int unsigned   cycle_count = 0;
    int            in_gap = 0;
    int            out_hold = 0;
    logic          quiet = 1'b0;

    function automatic t_range_result filter_step(t_echo_meas m);
        logic [31:0]   d;
        t_dist         a, b, c, lo, hi;
        t_ring_idx     p;
        t_range_result r;
        r.ch = m.ch;
        d = (32'(m.us) * 32'd1715 + 32'd5000) / 32'd10000;
        r.acc = m.echo && (d >= 32'(lim_min)) && (d <= 32'(lim_max));
        if (r.acc) begin
            p = wr_pos[m.ch];
            ring_mem[m.ch][p] = d[DIST_W-1:0];
            wr_pos[m.ch] = (p == 2'd2) ? 2'd0 : p + 2'd1;
            if (fill_cnt[m.ch] < 2'd3)
                fill_cnt[m.ch] = fill_cnt[m.ch] + 2'd1;
            a = ring_mem[m.ch][0];
            b = ring_mem[m.ch][1];
            c = ring_mem[m.ch][2];
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            case (fill_cnt[m.ch])
                2'd1: begin
                    held_dist[m.ch] = a;
                end
                2'd2: begin
                    held_dist[m.ch] = t_dist'((17'(a) + 17'(b)) >> 1);
                end
                default: begin
                    held_dist[m.ch] = (c <= lo) ? lo : (c >= hi) ? hi : c;
                end
            endcase
            last_tick[m.ch] = m.tick;
            seen_ok[m.ch] = 1'b1;
        end
        r.filt = held_dist[m.ch];
        r.fresh = seen_ok[m.ch] && (t_tick'(m.tick - last_tick[m.ch]) <= lim_stale);
        return r;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    task automatic sched_meas(logic ch, logic echo, logic [US_W-1:0] us, t_tick tk);
        pending_meas.push_back('{ch: ch, echo: echo, us: us, tick: tk});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MIN_DISTANCE: lim_min = val[DIST_W-1:0];
            CFG_MAX_DISTANCE: lim_max = val[DIST_W-1:0];
            CFG_STALE_TICKS:  lim_stale = val;
            default: ;
        endcase
    endtask

    // upper bits of the distance writes carry junk that must be dropped
    task automatic set_limits(t_dist mn, t_dist mx, t_tick st);
        write_reg(CFG_MIN_DISTANCE, {16'($urandom()), mn});
        write_reg(CFG_MAX_DISTANCE, {16'($urandom()), mx});
        write_reg(CFG_STALE_TICKS, st);
    endtask

    task automatic drain();
        while (pending_meas.size() != 0 || i_in_valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // measurement driver
    always @(posedge i_clk) begin : meas_driver
        t_echo_meas nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                due_results.push_back(filter_step('{ch: i_channel, echo: i_echo_seen,
                                                   us: i_pulse_us, tick: i_now_tick}));
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_meas.size() != 0) begin
                    nxt = pending_meas.pop_front();
                    i_in_valid <= 1'b1;
                    i_channel <= nxt.ch;
                    i_echo_seen <= nxt.echo;
                    i_pulse_us <= nxt.us;
                    i_now_tick <= nxt.tick;
                    if (!quiet && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 12);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : result_monitor
        t_range_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    err_count++;
                    $display(
                        "%0t: result with none due, expected nothing, actual ch %0d dist %0d acc %0d fresh %0d",
                        $time, o_out_channel, o_filtered_distance, o_sample_accepted, o_fresh);
                end else begin
                    want = due_results.pop_front();
                    check_field("out_channel", want.ch, o_out_channel);
                    check_field("filtered_distance", want.filt, o_filtered_distance);
                    check_field("sample_accepted", want.acc, o_sample_accepted);
                    check_field("fresh", want.fresh, o_fresh);
                end
            end
            if (out_hold > 0) begin
                out_hold--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_hold = $urandom_range(1, 12) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ultrasonic_range_median_filter test failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_dist           mn, mx;
        t_tick           st, tk, step_max;
        logic [US_W-1:0] us, lo_us, hi_us;
        longint unsigned tmp;
        foreach (ring_mem[i, j])
            ring_mem[i][j] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limits: range edges, no echo, ring fill and wrap, stale edge, tick wrap
        sched_meas(1'b1, 1'b0, 16'd0, 32'd0);
        sched_meas(1'b0, 1'b1, 16'd0, 32'd5);
        sched_meas(1'b0, 1'b1, 16'hFFFF, 32'd6);
        sched_meas(1'b0, 1'b0, 16'd1000, 32'd7);
        sched_meas(1'b0, 1'b1, 16'd113, 32'd8);
        sched_meas(1'b0, 1'b1, 16'd114, 32'd1000);
        sched_meas(1'b0, 1'b1, 16'd23327, 32'd1001);
        sched_meas(1'b0, 1'b1, 16'd23326, 32'd1002);
        sched_meas(1'b1, 1'b1, 16'd5000, 32'd1003);
        sched_meas(1'b0, 1'b1, 16'd3000, 32'd1004);
        sched_meas(1'b0, 1'b1, 16'd1000, 32'd1005);
        sched_meas(1'b0, 1'b0, 16'd500, 32'd1005 + 32'd10000000);
        sched_meas(1'b0, 1'b0, 16'd500, 32'd1006 + 32'd10000000);
        sched_meas(1'b1, 1'b1, 16'd5001, 32'hFFFF_FFF0);
        sched_meas(1'b1, 1'b0, 16'd0, 32'h0000_0010);
        sched_meas(1'b1, 1'b1, 16'hFFFF, 32'h0000_0011);
        drain();

        // widest window, zero stale limit, then writes to unused indexes
        set_limits(16'd0, 16'hFFFF, 32'd0);
        write_reg(CFG_UNUSED_LO, 32'h0000_FFFF);
        write_reg(CFG_UNUSED_HI, 32'hFFFF_FFFF);
        sched_meas(1'b0, 1'b1, 16'd0, 32'd50);
        sched_meas(1'b0, 1'b0, 16'd0, 32'd51);
        sched_meas(1'b1, 1'b1, 16'hFFFF, 32'd52);
        drain();

        // minimum above maximum
        set_limits(16'd500, 16'd499, 32'hFFFF_FFFF);
        sched_meas(1'b0, 1'b1, 16'd2915, 32'd60);
        sched_meas(1'b1, 1'b1, 16'd40000, 32'hFFFF_FFFF);
        drain();

        // single-point window
        set_limits(16'd500, 16'd500, 32'd10000000);
        sched_meas(1'b0, 1'b1, 16'd2915, 32'd70);
        sched_meas(1'b0, 1'b1, 16'd2910, 32'd71);
        drain();

        for (int k = 0; k < PHASES; k++) begin
            mn = t_dist'($urandom_range(0, 2000));
            mx = mn + t_dist'($urandom_range(0, 9000));
            st = $urandom_range(100, 5000);
            case (k)
                0: begin
                    mn = 16'd20;
                    mx = 16'd4000;
                    st = 32'd10000000;
                end
                1: begin
                    mn = 16'd0;
                    mx = 16'hFFFF;
                    st = 32'hFFFF_FFFF;
                end
                3: begin
                    mn = t_dist'($urandom_range(1000, 4000));
                    mx = mn - t_dist'($urandom_range(1, 1000));
                end
                4: begin
                    mn = t_dist'($urandom_range(0, 11239));
                    mx = mn;
                    st = 32'd0;
                end
                5: begin
                    mn = t_dist'($urandom_range(0, 500));
                    mx = t_dist'($urandom_range(3000, 11239));
                    st = 32'd1;
                end
                6: st = $urandom();
                default: ;
            endcase
            if (k == PHASES - 1)
                quiet = 1'b1;
            set_limits(mn, mx, st);

            tmp = 64'(mn) * 64'd10000 / 64'd1715;
            lo_us = (tmp > 64'd65535) ? 16'hFFFF : (tmp < 64'd2) ? 16'd0 : 16'(tmp - 64'd2);
            tmp = 64'(mx) * 64'd10000 / 64'd1715 + 64'd3;
            hi_us = (tmp > 64'd65535) ? 16'hFFFF : 16'(tmp);
            if (lo_us > hi_us) begin
                lo_us = 16'd0;
                hi_us = 16'hFFFF;
            end
            step_max = (st > 32'd100000) ? 32'd200000 : st * 32'd2 + 32'd4;
            tk = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 + $urandom_range(0, 4095)
                                              : $urandom();

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 9))
                    0, 1: us = 16'($urandom_range(0, 65535));
                    2: us = $urandom_range(0, 1) ? lo_us + 16'($urandom_range(0, 4))
                                                  : hi_us - 16'($urandom_range(0, 4));
                    default: us = 16'($urandom_range(lo_us, hi_us));
                endcase
                case ($urandom_range(0, 9))
                    0, 1: ;
                    8: tk = tk + $urandom_range(step_max, step_max * 4);
                    9: tk = $urandom();
                    default: tk = tk + $urandom_range(0, step_max);
                endcase
                sched_meas(1'($urandom()), $urandom_range(0, 6) != 0, us, tk);
            end
            drain();
        end

        repeat (6) @(posedge i_clk);
        if (err_count == 0)
            $display("ultrasonic_range_median_filter test passed");
        else
            $display("ultrasonic_range_median_filter test failed");
        $finish;
    end

endmodule

[ultrasonic_range_median_filter.f]
+incdir+hdl
hdl/urmf_pkg.sv
hdl/ultrasonic_range_median_filter.sv
hdl/urmf_checker.sv
bench/ultrasonic_range_median_filter_tb.sv
